// ===== rtl/obuh_pkg.sv =====
// obuh_pkg: shared types and constants for the offset binary unpack histogram
// used by the top level, front and back; depends on nothing
`default_nettype none

package obuh_pkg;

    localparam int BIN_BITS       = 16;
    localparam int HIST_BINS      = 65536;
    localparam int REPORT_BITS    = 32;
    localparam int DEF_NUM_POLS   = 2;
    localparam int DEF_COUNT_BITS = 32;

    // queue between front and back, and result queue
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam logic [BIN_BITS-1:0] SIGN_FLIP = 16'h8000;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    // classified word handed from front to back
    typedef struct packed {
        logic                       bump;
        logic                       rd_ok;
        logic                       pol;
        logic [BIN_BITS-1:0]        re_bin;
        logic [BIN_BITS-1:0]        im_bin;
        logic signed [BIN_BITS-1:0] re_value;
        logic signed [BIN_BITS-1:0] im_value;
    } t_cmd;

    typedef struct packed {
        logic signed [BIN_BITS-1:0] re_value;
        logic signed [BIN_BITS-1:0] im_value;
        logic [REPORT_BITS-1:0]     re_count;
        logic [REPORT_BITS-1:0]     im_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/offset_binary_unpack_histogram.sv =====
// offset_binary_unpack_histogram: top level, front, middle queue, back, result queue
// depends on obuh_pkg, obuh_fifo, obuh_front and obuh_back
//
//   channel   direction  handshake          payload
//   input     in         push / full        opcode, pol, re_raw, im_raw, bin_index
//   result    out        empty / pop        re_value, im_value, re_count, im_count
//
// one word a cycle sustained while the result side keeps popping: every word,
// sample or read, takes one pass through the single read-modify-write stage of the
// two histogram memories, between the middle queue and the result queue
// after reset a clearing pass writes zero to NUM_POLS * 65536 entries of each
// memory, one entry a cycle; full stays high for those cycles
// a stalled result side fills the result queue, then the middle queue, then full rises
`default_nettype none

module offset_binary_unpack_histogram #(
    parameter int NUM_POLS   = obuh_pkg::DEF_NUM_POLS,
    parameter int COUNT_BITS = obuh_pkg::DEF_COUNT_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic                                   i_opcode,
    input  wire logic                                   i_pol,
    input  wire logic        [obuh_pkg::BIN_BITS-1:0]   i_re_raw,
    input  wire logic        [obuh_pkg::BIN_BITS-1:0]   i_im_raw,
    input  wire logic        [obuh_pkg::BIN_BITS-1:0]   i_bin_index,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed      [obuh_pkg::BIN_BITS-1:0]   o_re_value,
    output logic signed      [obuh_pkg::BIN_BITS-1:0]   o_im_value,
    output logic             [obuh_pkg::REPORT_BITS-1:0] o_re_count,
    output logic             [obuh_pkg::REPORT_BITS-1:0] o_im_count
);

    import obuh_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    // front to middle queue
    logic                         mid_push;
    logic                         mid_full;
    logic                         mid_empty;
    t_cmd                         front_cmd;
    logic [CMD_W-1:0]             mid_data;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

    // back to result queue
    logic                         cmd_pop;
    logic                         clearing;
    logic                         res_push;
    t_result                      back_res;
    t_result                      res_head;
    logic [RES_W-1:0]             out_data;
    logic                         out_full;
    logic [OUT_CNT_W-1:0]         out_count;

    obuh_front #(
        .NUM_POLS (NUM_POLS)
    ) u_front (
        .i_push      (push),
        .o_full      (full),
        .i_opcode    (i_opcode),
        .i_pol       (i_pol),
        .i_re_raw    (i_re_raw),
        .i_im_raw    (i_im_raw),
        .i_bin_index (i_bin_index),
        .i_mid_full  (mid_full),
        .i_clearing  (clearing),
        .o_mid_push  (mid_push),
        .o_cmd       (front_cmd)
    );

    // middle queue lets the front keep taking words while the back waits
    obuh_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (mid_data),
        .o_full  (mid_full),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    obuh_back #(
        .NUM_POLS   (NUM_POLS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!mid_empty && (mid_count != '0)),
        .i_cmd       (t_cmd'(mid_data)),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_res_push  (res_push),
        .o_res       (back_res),
        .o_clearing  (clearing)
    );

    // result queue; the back never pushes without a free slot
    obuh_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_full  (out_full),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign res_head   = t_result'(out_data);
    assign o_re_value = res_head.re_value;
    assign o_im_value = res_head.im_value;
    // head word shown as it is whether or not the result queue is full
    assign o_re_count = res_head.re_count;
    assign o_im_count = out_full ? res_head.im_count : res_head.im_count;

endmodule

`default_nettype wire

// ===== rtl/obuh_fifo.sv =====
// obuh_fifo: small register queue with occupancy count
// used between front and back and for results; no package dependency
`default_nettype none

module obuh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    input  wire logic [WIDTH-1:0]               i_data,
    input  wire logic                           i_pop,
    output logic      [WIDTH-1:0]               o_data,
    output logic                                o_full,
    output logic                                o_empty,
    output logic      [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_store[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/obuh_front.sv =====
// obuh_front: accepts input words, converts samples and classifies the request
// depends on obuh_pkg; feeds the queue in front of obuh_back
`default_nettype none

module obuh_front #(
    parameter int NUM_POLS = obuh_pkg::DEF_NUM_POLS
) (
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire logic                           i_opcode,
    input  wire logic                           i_pol,
    input  wire logic [obuh_pkg::BIN_BITS-1:0]  i_re_raw,
    input  wire logic [obuh_pkg::BIN_BITS-1:0]  i_im_raw,
    input  wire logic [obuh_pkg::BIN_BITS-1:0]  i_bin_index,
    input  wire logic                           i_mid_full,
    input  wire logic                           i_clearing,
    output logic                                o_mid_push,
    output obuh_pkg::t_cmd                      o_cmd
);

    import obuh_pkg::*;

    logic pol_ok;
    logic is_read;

    assign o_full     = i_mid_full || i_clearing;
    assign o_mid_push = i_push && !o_full;
    assign pol_ok     = (32'(i_pol) < NUM_POLS);
    assign is_read    = (t_opcode'(i_opcode) == OP_READ);

    always_comb begin
        o_cmd.pol   = i_pol;
        o_cmd.bump  = !is_read && pol_ok;
        o_cmd.rd_ok = is_read && pol_ok;
        if (is_read) begin
            o_cmd.re_bin   = i_bin_index;
            o_cmd.im_bin   = i_bin_index;
            o_cmd.re_value = '0;
            o_cmd.im_value = '0;
        end else begin
            // raw code is the bin; top-bit flip gives two's complement
            o_cmd.re_bin   = i_re_raw;
            o_cmd.im_bin   = i_im_raw;
            o_cmd.re_value = signed'(i_re_raw ^ SIGN_FLIP);
            o_cmd.im_value = signed'(i_im_raw ^ SIGN_FLIP);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/obuh_back.sv =====
// obuh_back: histogram memories, clearing pass and read-modify-write stage
// depends on obuh_pkg; takes words from the middle queue, pushes results
`default_nettype none

module obuh_back #(
    parameter int NUM_POLS   = obuh_pkg::DEF_NUM_POLS,
    parameter int COUNT_BITS = obuh_pkg::DEF_COUNT_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cmd_valid,
    input  wire obuh_pkg::t_cmd                 i_cmd,
    output logic                                o_cmd_pop,
    input  wire logic [obuh_pkg::OUT_CNT_W-1:0] i_out_count,
    output logic                                o_res_push,
    output obuh_pkg::t_result                   o_res,
    output logic                                o_clearing
);

    import obuh_pkg::*;

    localparam int MEM_DEPTH = NUM_POLS * HIST_BINS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int ROOM_W    = OUT_CNT_W + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_re_mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] r_im_mem [MEM_DEPTH];

    logic                  r_clr;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic                  r_s1_valid;
    t_cmd                  r_s1;
    logic [COUNT_BITS-1:0] r_re_rd;
    logic [COUNT_BITS-1:0] r_im_rd;
    logic                  r_fwd_re_v;
    logic                  r_fwd_im_v;
    logic [ADDR_W-1:0]     r_fwd_re_addr;
    logic [ADDR_W-1:0]     r_fwd_im_addr;
    logic [COUNT_BITS-1:0] r_fwd_re_data;
    logic [COUNT_BITS-1:0] r_fwd_im_data;

    logic                  issue;
    logic [ADDR_W-1:0]     re_rd_addr;
    logic [ADDR_W-1:0]     im_rd_addr;
    logic [ADDR_W-1:0]     s1_re_addr;
    logic [ADDR_W-1:0]     s1_im_addr;
    logic [COUNT_BITS-1:0] cur_re;
    logic [COUNT_BITS-1:0] cur_im;
    logic [COUNT_BITS-1:0] inc_re;
    logic [COUNT_BITS-1:0] inc_im;
    logic                  mem_we;
    logic [ADDR_W-1:0]     re_wr_addr;
    logic [ADDR_W-1:0]     im_wr_addr;
    logic [COUNT_BITS-1:0] re_wr_data;
    logic [COUNT_BITS-1:0] im_wr_data;
    logic [REPORT_BITS-1:0] re_rep;
    logic [REPORT_BITS-1:0] im_rep;

    // issue only when the result queue has a slot for the word in flight too
    assign issue = i_cmd_valid && !r_clr &&
                   ((ROOM_W'(i_out_count) + ROOM_W'(r_s1_valid)) < ROOM_W'(OUT_DEPTH));
    assign o_cmd_pop  = issue;
    assign o_clearing = r_clr;

    // digitizer pair of a polarisation sits in the upper address bit
    assign re_rd_addr = ADDR_W'({i_cmd.pol, i_cmd.re_bin});
    assign im_rd_addr = ADDR_W'({i_cmd.pol, i_cmd.im_bin});
    assign s1_re_addr = ADDR_W'({r_s1.pol, r_s1.re_bin});
    assign s1_im_addr = ADDR_W'({r_s1.pol, r_s1.im_bin});

    // the read was taken at the same edge as the previous write
    assign cur_re = (r_fwd_re_v && r_fwd_re_addr == s1_re_addr) ? r_fwd_re_data : r_re_rd;
    assign cur_im = (r_fwd_im_v && r_fwd_im_addr == s1_im_addr) ? r_fwd_im_data : r_im_rd;
    assign inc_re = (cur_re == CNT_MAX) ? cur_re : cur_re + COUNT_BITS'(1);
    assign inc_im = (cur_im == CNT_MAX) ? cur_im : cur_im + COUNT_BITS'(1);

    assign mem_we     = r_clr || (r_s1_valid && r_s1.bump);
    assign re_wr_addr = r_clr ? r_clr_addr : s1_re_addr;
    assign im_wr_addr = r_clr ? r_clr_addr : s1_im_addr;
    assign re_wr_data = r_clr ? '0 : inc_re;
    assign im_wr_data = r_clr ? '0 : inc_im;

    generate
        if (COUNT_BITS > REPORT_BITS) begin : g_rep_sat
            assign re_rep = (|cur_re[COUNT_BITS-1:REPORT_BITS]) ? '1 : cur_re[REPORT_BITS-1:0];
            assign im_rep = (|cur_im[COUNT_BITS-1:REPORT_BITS]) ? '1 : cur_im[REPORT_BITS-1:0];
        end else begin : g_rep_ext
            assign re_rep = REPORT_BITS'(cur_re);
            assign im_rep = REPORT_BITS'(cur_im);
        end
    endgenerate

    assign o_res_push     = r_s1_valid;
    assign o_res.re_value = r_s1.re_value;
    assign o_res.im_value = r_s1.im_value;
    assign o_res.re_count = r_s1.rd_ok ? re_rep : '0;
    assign o_res.im_count = r_s1.rd_ok ? im_rep : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_re_mem[re_wr_addr] <= re_wr_data;
            r_im_mem[im_wr_addr] <= im_wr_data;
        end
        if (issue) begin
            r_re_rd <= r_re_mem[re_rd_addr];
            r_im_rd <= r_im_mem[im_rd_addr];
            r_s1    <= i_cmd;
        end
        r_fwd_re_addr <= s1_re_addr;
        r_fwd_im_addr <= s1_im_addr;
        r_fwd_re_data <= inc_re;
        r_fwd_im_data <= inc_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_re_v <= 1'b0;
            r_fwd_im_v <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_s1_valid <= issue;
            r_fwd_re_v <= r_s1_valid && r_s1.bump;
            r_fwd_im_v <= r_s1_valid && r_s1.bump;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/obuh_checker.sv =====
// obuh_checker: port-level checks on the offset binary unpack histogram
// depends on nothing; bound to the top level at the end of this file
`default_nettype none

module obuh_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               full,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic signed [15:0] o_re_value,
    input wire logic signed [15:0] o_im_value,
    input wire logic        [31:0] o_re_count,
    input wire logic        [31:0] o_im_count
);

    // the clearing pass holds off input right after reset
    a_full_after_reset: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) !$past(i_rst_n) |-> full)
        else $error("full low straight after reset");

    // no result may be waiting straight after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) !$past(i_rst_n) |-> empty)
        else $error("result shown straight after reset");

    // a word is either a sample (no counts) or a read (no values)
    a_sample_or_read: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) !empty |->
            ((o_re_count == 32'd0 && o_im_count == 32'd0) ||
             (o_re_value == 16'sd0 && o_im_value == 16'sd0)))
        else $error("result word carries both values and counts");

    // a waiting result holds while not taken
    a_result_holds: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (!empty && !pop) |=>
            (!empty && $stable(o_re_value) && $stable(o_im_value) &&
             $stable(o_re_count) && $stable(o_im_count)))
        else $error("waiting result changed or vanished");

endmodule

bind offset_binary_unpack_histogram obuh_checker u_obuh_checker (.*);

`default_nettype wire

// ===== test/tb_offset_binary_unpack_histogram.sv =====
`timescale 1ns / 100ps
// tb_offset_binary_unpack_histogram: self-checking bench for the offset binary unpack histogram
// predicts top-bit flips and per-digitizer bin counts, checks every result word in order
// depends on obuh_pkg and offset_binary_unpack_histogram

module tb_offset_binary_unpack_histogram;

    import obuh_pkg::*;

    // block configuration as built with its defaults
    localparam int NUM_POLS   = DEF_NUM_POLS;
    localparam int COUNT_BITS = DEF_COUNT_BITS;
    localparam longint unsigned COUNT_MAX =
        (COUNT_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << COUNT_BITS) - 64'd1);
    localparam longint unsigned REPORT_MAX = 64'hFFFF_FFFF;

    // full is held high through the clearing pass after reset, which writes NUM_POLS * 65536
    // entries, so the idle limit sits a few times above the length of that pass
    localparam int IDLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS = 1250;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        t_opcode         op;
        logic            pol;
        logic [15:0]     re_raw;
        logic [15:0]     im_raw;
        logic [15:0]     bin_index;
        bit              drain_first;   // hold off until every result is back
    } t_word;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_CHOKED
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_opcode = 1'b0;
    logic        i_pol = 1'b0;
    logic [15:0] i_re_raw = '0;
    logic [15:0] i_im_raw = '0;
    logic [15:0] i_bin_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic signed [15:0] o_re_value;
    logic signed [15:0] o_im_value;
    logic [31:0] o_re_count;
    logic [31:0] o_im_count;

    t_word       pending_words[$];
    t_result     expected_results[$];
    longint unsigned hist_counts[int];   // absent key means a zero count
    int          hot_bins[8];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          word_taken = 1'b0;

    // sender burst state and receiver stall pattern
    int          burst_left = 0;
    int          gap_left = 0;
    t_rx_mode    rx_mode = RX_FREE;
    int          rx_left = 0;

    offset_binary_unpack_histogram dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_opcode    (i_opcode),
        .i_pol       (i_pol),
        .i_re_raw    (i_re_raw),
        .i_im_raw    (i_im_raw),
        .i_bin_index (i_bin_index),
        .empty       (empty),
        .pop         (pop),
        .o_re_value  (o_re_value),
        .o_im_value  (o_im_value),
        .o_re_count  (o_re_count),
        .o_im_count  (o_im_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // one count up, held at the counter maximum
    function automatic void bump_bin(input int key);
        longint unsigned c;
        c = hist_counts.exists(key) ? hist_counts[key] : 64'd0;
        if (c < COUNT_MAX)
            hist_counts[key] = c + 64'd1;
    endfunction

    // counts wider than the report port saturate on the way out
    function automatic logic [31:0] read_bin(input int key);
        longint unsigned c;
        c = hist_counts.exists(key) ? hist_counts[key] : 64'd0;
        return (c > REPORT_MAX) ? 32'hFFFF_FFFF : c[31:0];
    endfunction

    // digitizer d = 2*pol + component, entry d*HIST_BINS + bin
    function automatic t_result unpack_and_count(input t_word w);
        t_result r;
        int      re_base;
        r = '0;
        re_base = int'(w.pol) * 2 * HIST_BINS;
        if (w.op == OP_SAMPLE) begin
            r.re_value = w.re_raw ^ SIGN_FLIP;
            r.im_value = w.im_raw ^ SIGN_FLIP;
            // bin addressed is the raw offset binary code; out of range pol counts nothing
            if (int'(w.pol) < NUM_POLS) begin
                bump_bin(re_base + int'(w.re_raw));
                bump_bin(re_base + HIST_BINS + int'(w.im_raw));
            end
        end else if (int'(w.pol) < NUM_POLS) begin
            r.re_count = read_bin(re_base + int'(w.bin_index));
            r.im_count = read_bin(re_base + HIST_BINS + int'(w.bin_index));
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%08h actual 0x%08h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic t_word make_word(input t_opcode op, input logic pol,
                                        input logic [15:0] re_raw, input logic [15:0] im_raw,
                                        input logic [15:0] bin_index);
        t_word w;
        w.op = op;
        w.pol = pol;
        w.re_raw = re_raw;
        w.im_raw = im_raw;
        w.bin_index = bin_index;
        w.drain_first = 1'b0;
        return w;
    endfunction

    // pick a bin that is likely to hold counts, else any code at all
    function automatic logic [15:0] pick_bin();
        return ($urandom_range(0, 99) < 70) ? 16'(hot_bins[$urandom_range(0, 7)])
                                            : 16'($urandom);
    endfunction

    initial begin
        t_word w;
        hot_bins = '{32'h0000, 32'hFFFF, 32'h8000, 32'h7FFF, 0, 0, 0, 0};
        for (int i = 4; i < 8; i++)
            hot_bins[i] = $urandom_range(0, 16'hFFFF);

        // directed: code extremes on both polarisations, bin_index ignored on samples
        pending_words.push_back(make_word(OP_SAMPLE, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF));
        pending_words.push_back(make_word(OP_SAMPLE, 1'b0, 16'h8000, 16'h7FFF, 16'h0000));
        pending_words.push_back(make_word(OP_SAMPLE, 1'b0, 16'hFFFF, 16'h0000, 16'h5A5A));
        pending_words.push_back(make_word(OP_SAMPLE, 1'b0, 16'h0000, 16'h0000, 16'hA5A5));
        pending_words.push_back(make_word(OP_SAMPLE, 1'b1, 16'h7FFF, 16'h8000, 16'hFFFF));
        pending_words.push_back(make_word(OP_SAMPLE, 1'b1, 16'h0000, 16'h0000, 16'h0000));
        pending_words.push_back(make_word(OP_SAMPLE, 1'b1, 16'h0000, 16'hFFFF, 16'h1234));
        // reads with raw fields set to garbage, which they must ignore
        pending_words.push_back(make_word(OP_READ, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000));
        pending_words.push_back(make_word(OP_READ, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF));
        pending_words.push_back(make_word(OP_READ, 1'b0, 16'hFFFF, 16'h0000, 16'h8000));
        pending_words.push_back(make_word(OP_READ, 1'b0, 16'h5555, 16'hAAAA, 16'h7FFF));
        pending_words.push_back(make_word(OP_READ, 1'b1, 16'hAAAA, 16'h5555, 16'h0000));
        pending_words.push_back(make_word(OP_READ, 1'b1, 16'h0000, 16'h0000, 16'h7FFF));
        pending_words.push_back(make_word(OP_READ, 1'b1, 16'hFFFF, 16'hFFFF, 16'h8000));
        pending_words.push_back(make_word(OP_READ, 1'b1, 16'h0000, 16'h0000, 16'hFFFF));
        // never-touched bin on both polarisations reads zero
        pending_words.push_back(make_word(OP_READ, 1'b0, 16'h0000, 16'h0000, 16'h1234));
        pending_words.push_back(make_word(OP_READ, 1'b1, 16'h0000, 16'h0000, 16'h1234));
        // read right after sample of the same bin
        pending_words.push_back(make_word(OP_SAMPLE, 1'b0, 16'h8000, 16'h8000, 16'h8000));
        pending_words.push_back(make_word(OP_READ, 1'b0, 16'h0000, 16'h0000, 16'h8000));

        // random: most samples land in a few hot bins so reads see counts grow
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if ($urandom_range(0, 99) < 55)
                w = make_word(OP_SAMPLE, 1'($urandom), pick_bin(), pick_bin(), 16'($urandom));
            else
                w = make_word(OP_READ, 1'($urandom), 16'($urandom), 16'($urandom), pick_bin());
            // sender waits for a full drain once early and once midway
            w.drain_first = (i == 0) || (i == RANDOM_WORDS / 2);
            pending_words.push_back(w);
        end

        // synchronous reset
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------- driver

    // words change on the falling edge; a word held on the port stays until taken
    always @(negedge i_clk) begin : drive_words
        bit     hold_word;
        bit     push_next;
        t_word  w;
        hold_word = 1'b0;
        push_next = 1'b0;
        if (i_rst_n) begin
            if (word_taken) begin
                void'(pending_words.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    // a zero gap now and then gives long stretches at full rate
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = $urandom_range(1, 24);
                end
            end
            if (push && !word_taken) begin
                hold_word = 1'b1;
                push_next = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() != 0) begin
                if (!pending_words[0].drain_first || expected_results.size() == 0)
                    push_next = 1'b1;
            end
            if (push_next && !hold_word) begin
                w = pending_words[0];
                i_opcode    <= w.op;
                i_pol       <= w.pol;
                i_re_raw    <= w.re_raw;
                i_im_raw    <= w.im_raw;
                i_bin_index <= w.bin_index;
            end
        end
        push <= push_next;
    end

    // receiver pattern: free running, coin toss, or mostly stalled, in stretches
    always @(negedge i_clk) begin : drive_pop
        bit pop_next;
        pop_next = 1'b0;
        if (i_rst_n) begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_left = $urandom_range(16, 120);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:   pop_next = 1'b1;
                RX_RANDOM: pop_next = 1'($urandom_range(0, 1));
                default:   pop_next = ($urandom_range(0, 5) == 0);
            endcase
        end
        pop <= pop_next;
    end

    // ---------------------------------------------------------------- monitor

    // results checked before the same edge's input word is predicted; with the queues
    // and stage registered, a result can never belong to the word taken alongside it
    always @(posedge i_clk) begin : watch_ports
        t_result want;
        t_word   w;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with none expected, actual re %0d im %0d"
                             , $time, o_re_value, o_im_value);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("re_value", 32'(want.re_value), 32'(o_re_value));
                    check_field("im_value", 32'(want.im_value), 32'(o_im_value));
                    check_field("re_count", want.re_count, o_re_count);
                    check_field("im_count", want.im_count, o_im_count);
                end
            end
            if (push && !full) begin
                word_taken = 1'b1;
                w = pending_words[0];
                expected_results.push_back(unpack_and_count(w));
            end
            // watchdog on cycles where neither side moves a word
            if (word_taken || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule

// ===== offset_binary_unpack_histogram.f =====
rtl/obuh_pkg.sv
rtl/obuh_fifo.sv
rtl/obuh_front.sv
rtl/obuh_back.sv
rtl/offset_binary_unpack_histogram.sv
rtl/obuh_checker.sv
test/tb_offset_binary_unpack_histogram.sv
